FILE: hw/rtl/esbrt_pkg.sv
// shared types, codes and defaults of the exact-size block reuse table
`timescale 1ns / 1ps

package esbrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int DATA_W            = 32;
    localparam int CFG_IDX_W         = 1;

    localparam logic [DATA_W-1:0] HEAP_BASE_RST  = 32'd4096;
    localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'd1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [3:0] STATUS_REUSED       = 4'd0;
    localparam logic [3:0] STATUS_NEW          = 4'd1;
    localparam logic [3:0] STATUS_NULL         = 4'd2;
    localparam logic [3:0] STATUS_FREED        = 4'd3;
    localparam logic [3:0] STATUS_EMPTY        = 4'd4;
    localparam logic [3:0] STATUS_DOUBLE       = 4'd5;
    localparam logic [3:0] STATUS_UNKNOWN      = 4'd6;
    localparam logic [3:0] STATUS_FULL         = 4'd7;
    localparam logic [3:0] STATUS_EXHAUSTED    = 4'd8;
    localparam logic [3:0] STATUS_CLEARED      = 4'd9;
    localparam logic [3:0] STATUS_CLEARED_BUSY = 4'd10;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] bytes;
        logic [DATA_W-1:0] base;
    } entry_t;

endpackage

FILE: hw/rtl/esbrt_mem.sv
// block table memory, one write port and one registered read port
`timescale 1ns / 1ps

module esbrt_mem #(
    parameter int ENTRIES = esbrt_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output esbrt_pkg::entry_t   rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  esbrt_pkg::entry_t   wr_data
);

    esbrt_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

FILE: hw/rtl/esbrt_ctrl.sv
// request sequencer: table scan, entry update, bump pointer and result register
`timescale 1ns / 1ps

module esbrt_ctrl #(
    parameter int ENTRIES = esbrt_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [esbrt_pkg::DATA_W-1:0]  block_size,
    input  logic [esbrt_pkg::DATA_W-1:0]  block_address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [esbrt_pkg::DATA_W-1:0]  result_address,
    output logic [3:0]                    status,
    input  logic [esbrt_pkg::DATA_W-1:0]  heap_base,
    input  logic [esbrt_pkg::DATA_W-1:0]  heap_limit,
    output logic                          mem_rd_en,
    output logic [IDX_W-1:0]              mem_rd_idx,
    input  esbrt_pkg::entry_t             mem_rd_data,
    output logic                          mem_wr_en,
    output logic [IDX_W-1:0]              mem_wr_idx,
    output esbrt_pkg::entry_t             mem_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NEW,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [esbrt_pkg::DATA_W-1:0]   size_reg, size_next;
    logic [esbrt_pkg::DATA_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               busy_cnt_reg, busy_cnt_next;
    logic [esbrt_pkg::DATA_W-1:0]   bytes_reg, bytes_next;
    logic [esbrt_pkg::DATA_W-1:0]   res_addr_reg, res_addr_next;
    logic [3:0]                     res_status_reg, res_status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [esbrt_pkg::DATA_W-1:0]   out_addr_reg, out_addr_next;
    logic [3:0]                     out_status_reg, out_status_next;

    logic                           accept;
    logic                           last_entry;
    logic [esbrt_pkg::DATA_W:0]     need_bytes;
    logic                           exhausted;
    logic                           table_full;

    assign in_stall       = (state_reg != ST_IDLE);
    assign accept         = in_valid && !in_stall;
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign need_bytes = {1'b0, bytes_reg} + {1'b0, size_reg};
    assign exhausted  = need_bytes > {1'b0, heap_limit};
    assign table_full = (count_reg == CNT_W'(ENTRIES));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        busy_cnt_next   = busy_cnt_reg;
        bytes_next      = bytes_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_idx      = idx_reg + IDX_W'(1);
        mem_wr_en       = 1'b0;
        mem_wr_idx      = idx_reg;
        mem_wr_data     = mem_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = operation;
                    size_next     = block_size;
                    addr_next     = block_address;
                    idx_next      = '0;
                    res_addr_next = '0;
                    mem_rd_en     = 1'b1;
                    mem_rd_idx    = '0;
                    state_next    = ST_DONE;
                    case (operation)
                        esbrt_pkg::OP_ALLOC:
                        begin
                            state_next = (count_reg == '0) ? ST_NEW : ST_SCAN;
                        end
                        esbrt_pkg::OP_FREE:
                        begin
                            if (block_address == '0)
                            begin
                                res_status_next = esbrt_pkg::STATUS_NULL;
                            end
                            else if (count_reg == '0)
                            begin
                                res_status_next = esbrt_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        esbrt_pkg::OP_CLEAR:
                        begin
                            res_status_next = (busy_cnt_reg != '0)
                                ? esbrt_pkg::STATUS_CLEARED_BUSY
                                : esbrt_pkg::STATUS_CLEARED;
                            count_next      = '0;
                            busy_cnt_next   = '0;
                            bytes_next      = '0;
                        end
                        default:
                        begin
                            res_status_next = esbrt_pkg::STATUS_NULL;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (op_reg == esbrt_pkg::OP_ALLOC)
                begin
                    if (!mem_rd_data.busy && (mem_rd_data.bytes == size_reg))
                    begin
                        mem_wr_en        = 1'b1;
                        mem_wr_data.busy = 1'b1;
                        busy_cnt_next    = busy_cnt_reg + CNT_W'(1);
                        res_addr_next    = mem_rd_data.base;
                        res_status_next  = esbrt_pkg::STATUS_REUSED;
                        state_next       = ST_DONE;
                    end
                    else if (last_entry)
                    begin
                        state_next = ST_NEW;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        mem_rd_en = 1'b1;
                    end
                end
                else
                begin
                    if (mem_rd_data.base == addr_reg)
                    begin
                        if (!mem_rd_data.busy)
                        begin
                            res_status_next = esbrt_pkg::STATUS_DOUBLE;
                        end
                        else
                        begin
                            mem_wr_en        = 1'b1;
                            mem_wr_data.busy = 1'b0;
                            busy_cnt_next    = busy_cnt_reg - CNT_W'(1);
                            res_status_next  = esbrt_pkg::STATUS_FREED;
                        end
                        state_next = ST_DONE;
                    end
                    else if (last_entry)
                    begin
                        res_status_next = esbrt_pkg::STATUS_UNKNOWN;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        mem_rd_en = 1'b1;
                    end
                end
            end
            ST_NEW:
            begin
                if (table_full)
                begin
                    res_status_next = esbrt_pkg::STATUS_FULL;
                end
                else if (exhausted)
                begin
                    res_status_next = esbrt_pkg::STATUS_EXHAUSTED;
                end
                else
                begin
                    mem_wr_en         = 1'b1;
                    mem_wr_idx        = count_reg[IDX_W-1:0];
                    mem_wr_data.busy  = 1'b1;
                    mem_wr_data.bytes = size_reg;
                    mem_wr_data.base  = heap_base + bytes_reg;
                    count_next        = count_reg + CNT_W'(1);
                    busy_cnt_next     = busy_cnt_reg + CNT_W'(1);
                    bytes_next        = need_bytes[esbrt_pkg::DATA_W-1:0];
                    res_addr_next     = heap_base + bytes_reg;
                    res_status_next   = esbrt_pkg::STATUS_NEW;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            busy_cnt_reg  <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            busy_cnt_reg  <= busy_cnt_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    busy_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_cnt_reg <= count_reg)
        else $error("busy block count exceeds table fill");

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("table fill beyond capacity");

    no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && (mem_wr_idx == mem_rd_idx)))
        else $error("read and write of one entry in the same cycle");

    fill_only_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && !(accept && (operation == esbrt_pkg::OP_CLEAR))
        |=> (count_reg != '0))
        else $error("table fill dropped without a clear");

    new_entry_in_free_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEW) && mem_wr_en |-> !table_full && !exhausted)
        else $error("new entry written with no room");

endmodule

FILE: hw/rtl/exact_size_block_reuse_table_unit.sv
// top level of the exact-size block reuse table: config registers and block wiring
`timescale 1ns / 1ps

// Allocate hands back the oldest free block of exactly the requested size, or
// carves a new one from a bump pointer at heap_base; free marks a block free by
// base address; clear empties the table at once. Requests are handled one at a
// time. The table sits in a single memory that gives one entry per cycle, so an
// allocate or free scans the entries in order from the first, one at a time,
// until it finds a match or reaches the last; clear, null free and a free of an
// empty table skip the scan. The next request is taken while the last result
// still waits in the output register. No clearing pass runs after reset. Write
// heap_base and heap_limit only while no request is in flight.
module exact_size_block_reuse_table_unit #(
    parameter int TABLE_ENTRIES = esbrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       operation,
    input  logic [esbrt_pkg::DATA_W-1:0]     block_size,
    input  logic [esbrt_pkg::DATA_W-1:0]     block_address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [esbrt_pkg::DATA_W-1:0]     result_address,
    output logic [3:0]                       status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [esbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [esbrt_pkg::DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [esbrt_pkg::DATA_W-1:0] heap_base_reg, heap_base_next;
    logic [esbrt_pkg::DATA_W-1:0] heap_limit_reg, heap_limit_next;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_idx;
    esbrt_pkg::entry_t  mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_idx;
    esbrt_pkg::entry_t  mem_wr_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        heap_base_next  = heap_base_reg;
        heap_limit_next = heap_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                esbrt_pkg::CFG_HEAP_BASE:  heap_base_next  = cfg_data;
                esbrt_pkg::CFG_HEAP_LIMIT: heap_limit_next = cfg_data;
                default:                   heap_base_next  = heap_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= esbrt_pkg::HEAP_BASE_RST;
            heap_limit_reg <= esbrt_pkg::HEAP_LIMIT_RST;
        end
        else
        begin
            heap_base_reg  <= heap_base_next;
            heap_limit_reg <= heap_limit_next;
        end
    end

    esbrt_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_idx  (mem_rd_idx),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_idx  (mem_wr_idx),
        .wr_data (mem_wr_data)
    );

    esbrt_ctrl #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .block_size     (block_size),
        .block_address  (block_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .status         (status),
        .heap_base      (heap_base_reg),
        .heap_limit     (heap_limit_reg),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_idx     (mem_rd_idx),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_idx     (mem_wr_idx),
        .mem_wr_data    (mem_wr_data)
    );

endmodule
